### rtl/mcmf_pkg.sv
package mcmf_pkg;

   // Width of a stored vertex distance.
   localparam int DIST_W = 25;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_VTX = 2'd1;
   localparam logic [1:0] ST_NEG_CYC = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [1:0] CSR_SOURCE_VERTEX = 2'd1;
   localparam logic [1:0] CSR_SINK_VERTEX   = 2'd2;

   typedef struct packed {
      logic [5:0]         edge_tail;
      logic [5:0]         edge_head;
      logic [15:0]        edge_capacity;
      logic signed [15:0] edge_cost;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic [5:0]         edge_number;
      logic [15:0]        edge_flow;
      logic [21:0]        total_flow;
      logic signed [47:0] total_cost;
      logic [1:0]         status;
      logic               last_result;
   } rsp_type;

   // One memory row holds an edge: its forward arc and its reverse arc.
   typedef struct packed {
      logic [5:0]         tail;
      logic [5:0]         head;
      logic signed [15:0] cost;
      logic [15:0]        res_fwd;
      logic [15:0]        res_rev;
   } arc_row_type;

   // One arc as the solver sees it.
   typedef struct packed {
      logic [5:0]         tail;
      logic [5:0]         head;
      logic [15:0]        res;
      logic signed [16:0] cost;
   } arc_type;

   // Pick the forward arc (half low) or the reverse arc (half high) of a row.
   function automatic arc_type arc_of(arc_row_type row, logic half);
      arc_type            arc;
      logic signed [16:0] c;
      c = {row.cost[15], row.cost};
      if (!half) begin
         arc.tail = row.tail;
         arc.head = row.head;
         arc.res  = row.res_fwd;
         arc.cost = c;
      end else begin
         arc.tail = row.head;
         arc.head = row.tail;
         arc.res  = row.res_rev;
         arc.cost = -c;
      end
      return arc;
   endfunction

endpackage

### rtl/mcmf_ram.sv
module mcmf_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/min_cost_max_flow_engine.sv
// Edge load: one edge per cycle, no result, while the engine is idle.
// Solve: per Bellman-Ford pass, a vertex without a distance is skipped; one with a distance
// has it read, then every arc row read and checked, plus a head read per arc leaving it with
// residual left, through single-port memories; repeated per augmenting round.
// Results: one per loaded edge, each sent after its row is read, when the output is not stalled.
// Reset (synchronous, active high) clears control state and the configuration registers;
// the arc and vertex memories are not cleared and need no clearing pass.
module min_cost_max_flow_engine #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mcmf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mcmf_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_wdata
);
   import mcmf_pkg::*;

   localparam int VXW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW  = $clog2(MAX_VERTICES + 1);
   localparam int RW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int AW  = RW + 1;
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int VW  = DIST_W + AW;
   localparam int ROW_W = $bits(arc_row_type);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_START      = 5'd1;
   localparam logic [4:0] S_REACH_INIT = 5'd2;
   localparam logic [4:0] S_REACH_RD   = 5'd3;
   localparam logic [4:0] S_REACH_CHK  = 5'd4;
   localparam logic [4:0] S_BF_INIT    = 5'd5;
   localparam logic [4:0] S_BF_VSEL    = 5'd6;
   localparam logic [4:0] S_BF_VWAIT   = 5'd7;
   localparam logic [4:0] S_BF_ARD     = 5'd8;
   localparam logic [4:0] S_BF_ACHK    = 5'd9;
   localparam logic [4:0] S_BF_HCMP    = 5'd10;
   localparam logic [4:0] S_BF_PASS    = 5'd11;
   localparam logic [4:0] S_SINK_RD    = 5'd12;
   localparam logic [4:0] S_SINK_WAIT  = 5'd13;
   localparam logic [4:0] S_WALK_VSEL  = 5'd14;
   localparam logic [4:0] S_WALK_PWAIT = 5'd15;
   localparam logic [4:0] S_WALK_ACHK  = 5'd16;
   localparam logic [4:0] S_AUG_VSEL   = 5'd17;
   localparam logic [4:0] S_AUG_PWAIT  = 5'd18;
   localparam logic [4:0] S_AUG_UPD    = 5'd19;
   localparam logic [4:0] S_ACC_MUL    = 5'd20;
   localparam logic [4:0] S_ACC_ADD    = 5'd21;
   localparam logic [4:0] S_OUT_RD     = 5'd22;
   localparam logic [4:0] S_OUT_WAIT   = 5'd23;

   // Configuration registers.
   logic [6:0] vcount_ff;
   logic [5:0] src_ff;
   logic [5:0] snk_ff;

   // Control and datapath registers.
   logic [4:0]               state_ff, state_in;
   logic [NW-1:0]            n_ff, n_in;
   logic [EW-1:0]            edges_ff, edges_in;
   logic [5:0]               maxv_ff, maxv_in;
   logic [AW-1:0]            a_ff, a_in;
   logic [NW-1:0]            v_ff, v_in;
   logic [NW-1:0]            pass_ff, pass_in;
   logic [NW-1:0]            steps_ff, steps_in;
   logic                     changed_ff, changed_in;
   logic                     updated_ff, updated_in;
   logic [MAX_VERTICES-1:0]  seen_ff, seen_in;
   logic [MAX_VERTICES-1:0]  dvalid_ff, dvalid_in;
   logic signed [DIST_W-1:0] dist_v_ff, dist_v_in;
   logic signed [DIST_W-1:0] k_ff, k_in;
   logic [VXW-1:0]           h_ff, h_in;
   logic [16:0]              incr_ff, incr_in;
   logic signed [DIST_W-1:0] dist_sink_ff, dist_sink_in;
   logic signed [DIST_W+17:0] prod_ff, prod_in;
   logic [22:0]              flow_ff, flow_in;
   logic signed [47:0]       cost_ff, cost_in;
   logic [1:0]               status_ff, status_in;
   logic [RW-1:0]            i_ff, i_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Memory ports.
   logic              am_wr_en, am_rd_en;
   logic [RW-1:0]     am_wr_addr, am_rd_addr;
   arc_row_type       am_wr_data, am_rd_data;
   logic              vm_wr_en, vm_rd_en;
   logic [VXW-1:0]    vm_wr_addr, vm_rd_addr;
   logic [VW-1:0]     vm_wr_data, vm_rd_data;

   // Helpers.
   logic                     req_take;
   logic [NW-1:0]            n_calc;
   logic                     bad_vtx;
   logic [EW:0]              arc_cnt;
   logic [AW-1:0]            arc_last;
   arc_type                  cur_arc;
   logic signed [DIST_W-1:0] vrd_dist;
   logic [AW-1:0]            vrd_parent;
   logic signed [DIST_W-1:0] k_calc;
   logic [VXW-1:0]           src_vx, snk_vx, v_vx;
   logic                     out_last;
   logic                     out_free;

   mcmf_ram #(.DEPTH(MAX_EDGES), .WIDTH(ROW_W)) u_arc_ram (
      .clock   (clock),
      .wr_en   (am_wr_en),
      .wr_addr (am_wr_addr),
      .wr_data (am_wr_data),
      .rd_en   (am_rd_en),
      .rd_addr (am_rd_addr),
      .rd_data (am_rd_data)
   );

   mcmf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vm_wr_en),
      .wr_addr (vm_wr_addr),
      .wr_data (vm_wr_data),
      .rd_en   (vm_rd_en),
      .rd_addr (vm_rd_addr),
      .rd_data (vm_rd_data)
   );

   // Derived values used by several states.
   assign req_take   = req_valid && !req_stall;
   assign n_calc     = (32'(vcount_ff) < MAX_VERTICES) ? NW'(vcount_ff) : NW'(MAX_VERTICES);
   assign bad_vtx    = (n_calc == '0) || (32'(src_ff) >= 32'(n_calc))
                    || (32'(snk_ff) >= 32'(n_calc)) || (src_ff == snk_ff)
                    || (32'(maxv_ff) >= 32'(n_calc));
   assign arc_cnt    = {edges_ff, 1'b0};
   assign arc_last   = AW'(arc_cnt - 1'b1);
   assign cur_arc    = arc_of(am_rd_data, a_ff[0]);
   assign vrd_dist   = signed'(vm_rd_data[VW-1:AW]);
   assign vrd_parent = vm_rd_data[AW-1:0];
   assign k_calc     = dist_v_ff + DIST_W'(cur_arc.cost);
   assign src_vx     = VXW'(src_ff);
   assign snk_vx     = VXW'(snk_ff);
   assign v_vx       = v_ff[VXW-1:0];
   assign out_last   = (EW'(i_ff) == (edges_ff - 1'b1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: load, reachability sweep, Bellman-Ford, path walk, augment, output.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      edges_in     = edges_ff;
      maxv_in      = maxv_ff;
      a_in         = a_ff;
      v_in         = v_ff;
      pass_in      = pass_ff;
      steps_in     = steps_ff;
      changed_in   = changed_ff;
      updated_in   = updated_ff;
      seen_in      = seen_ff;
      dvalid_in    = dvalid_ff;
      dist_v_in    = dist_v_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      incr_in      = incr_ff;
      dist_sink_in = dist_sink_ff;
      prod_in      = prod_ff;
      flow_in      = flow_ff;
      cost_in      = cost_ff;
      status_in    = status_ff;
      i_in         = i_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      am_wr_en     = 1'b0;
      am_wr_addr   = a_ff[AW-1:1];
      am_wr_data   = am_rd_data;
      am_rd_en     = 1'b0;
      am_rd_addr   = a_ff[AW-1:1];
      vm_wr_en     = 1'b0;
      vm_wr_addr   = h_ff;
      vm_wr_data   = {k_ff, a_ff};
      vm_rd_en     = 1'b0;
      vm_rd_addr   = v_vx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (edges_ff < EW'(MAX_EDGES)) begin
                  am_wr_en           = 1'b1;
                  am_wr_addr         = RW'(edges_ff);
                  am_wr_data.tail    = req_data.edge_tail;
                  am_wr_data.head    = req_data.edge_head;
                  am_wr_data.cost    = req_data.edge_cost;
                  am_wr_data.res_fwd = req_data.edge_capacity;
                  am_wr_data.res_rev = '0;
                  edges_in           = edges_ff + 1'b1;
                  if (req_data.edge_tail > maxv_in) begin
                     maxv_in = req_data.edge_tail;
                  end
                  if (req_data.edge_head > maxv_in) begin
                     maxv_in = req_data.edge_head;
                  end
               end
               if (req_data.last_edge) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            n_in    = n_calc;
            flow_in = '0;
            cost_in = '0;
            i_in    = '0;
            if (bad_vtx) begin
               status_in = ST_BAD_VTX;
               state_in  = S_OUT_RD;
            end else begin
               status_in = ST_OK;
               state_in  = S_REACH_INIT;
            end
         end
         // Reachability: sweep all arcs until the seen set stops growing.
         S_REACH_INIT: begin
            seen_in         = '0;
            seen_in[src_vx] = 1'b1;
            changed_in      = 1'b0;
            a_in            = '0;
            state_in        = S_REACH_RD;
         end
         S_REACH_RD: begin
            am_rd_en = 1'b1;
            state_in = S_REACH_CHK;
         end
         S_REACH_CHK: begin
            if ((cur_arc.res != '0) && seen_ff[VXW'(cur_arc.tail)]
                && !seen_ff[VXW'(cur_arc.head)]) begin
               seen_in[VXW'(cur_arc.head)] = 1'b1;
               changed_in                  = 1'b1;
            end
            if (a_ff == arc_last) begin
               a_in = '0;
               if (changed_in) begin
                  changed_in = 1'b0;
                  state_in   = S_REACH_RD;
               end else if (seen_ff[snk_vx]) begin
                  state_in = S_BF_INIT;
               end else begin
                  state_in = S_OUT_RD;
               end
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_REACH_RD;
            end
         end
         // Bellman-Ford: vertices in order, arcs of each vertex in id order.
         S_BF_INIT: begin
            dvalid_in         = '0;
            dvalid_in[src_vx] = 1'b1;
            vm_wr_en          = 1'b1;
            vm_wr_addr        = src_vx;
            vm_wr_data        = {{DIST_W{1'b0}}, {AW{1'b0}}};
            pass_in           = NW'(1);
            updated_in        = 1'b0;
            v_in              = '0;
            state_in          = S_BF_VSEL;
         end
         S_BF_VSEL: begin
            if (v_ff == n_ff) begin
               state_in = S_BF_PASS;
            end else if (!dvalid_ff[v_vx]) begin
               v_in = v_ff + 1'b1;
            end else begin
               vm_rd_en = 1'b1;
               state_in = S_BF_VWAIT;
            end
         end
         S_BF_VWAIT: begin
            dist_v_in = vrd_dist;
            a_in      = '0;
            state_in  = S_BF_ARD;
         end
         S_BF_ARD: begin
            am_rd_en = 1'b1;
            state_in = S_BF_ACHK;
         end
         S_BF_ACHK: begin
            if ((VXW'(cur_arc.tail) == v_vx) && (cur_arc.res != '0)) begin
               k_in       = k_calc;
               h_in       = VXW'(cur_arc.head);
               vm_rd_en   = 1'b1;
               vm_rd_addr = VXW'(cur_arc.head);
               state_in   = S_BF_HCMP;
            end else if (a_ff == arc_last) begin
               v_in     = v_ff + 1'b1;
               state_in = S_BF_VSEL;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_BF_ARD;
            end
         end
         S_BF_HCMP: begin
            if (!dvalid_ff[h_ff] || (vrd_dist > k_ff)) begin
               vm_wr_en        = 1'b1;
               dvalid_in[h_ff] = 1'b1;
               updated_in      = 1'b1;
               if (h_ff == v_vx) begin
                  dist_v_in = k_ff;
               end
            end
            if (a_ff == arc_last) begin
               v_in     = v_ff + 1'b1;
               state_in = S_BF_VSEL;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_BF_ARD;
            end
         end
         S_BF_PASS: begin
            if (!updated_ff) begin
               state_in = S_SINK_RD;
            end else if (pass_ff >= n_ff) begin
               status_in = ST_NEG_CYC;
               state_in  = S_OUT_RD;
            end else begin
               pass_in    = pass_ff + 1'b1;
               updated_in = 1'b0;
               v_in       = '0;
               state_in   = S_BF_VSEL;
            end
         end
         S_SINK_RD: begin
            if (!dvalid_ff[snk_vx]) begin
               state_in = S_OUT_RD;
            end else begin
               vm_rd_en   = 1'b1;
               vm_rd_addr = snk_vx;
               state_in   = S_SINK_WAIT;
            end
         end
         S_SINK_WAIT: begin
            dist_sink_in = vrd_dist;
            v_in         = NW'(snk_ff);
            steps_in     = '0;
            incr_in      = '1;
            state_in     = S_WALK_VSEL;
         end
         // Path walk from the sink: find the bottleneck residual.
         S_WALK_VSEL: begin
            if (v_ff == NW'(src_ff)) begin
               if (incr_ff == '0) begin
                  status_in = ST_NEG_CYC;
                  state_in  = S_OUT_RD;
               end else begin
                  v_in     = NW'(snk_ff);
                  state_in = S_AUG_VSEL;
               end
            end else if (steps_ff >= n_ff) begin
               status_in = ST_NEG_CYC;
               state_in  = S_OUT_RD;
            end else begin
               vm_rd_en = 1'b1;
               state_in = S_WALK_PWAIT;
            end
         end
         S_WALK_PWAIT: begin
            a_in       = vrd_parent;
            am_rd_en   = 1'b1;
            am_rd_addr = vrd_parent[AW-1:1];
            state_in   = S_WALK_ACHK;
         end
         S_WALK_ACHK: begin
            if ({1'b0, cur_arc.res} < incr_ff) begin
               incr_in = {1'b0, cur_arc.res};
            end
            v_in     = NW'(cur_arc.tail);
            steps_in = steps_ff + 1'b1;
            state_in = S_WALK_VSEL;
         end
         // Augment along the same path; both arcs of an edge share one row.
         S_AUG_VSEL: begin
            if (v_ff == NW'(src_ff)) begin
               state_in = S_ACC_MUL;
            end else begin
               vm_rd_en = 1'b1;
               state_in = S_AUG_PWAIT;
            end
         end
         S_AUG_PWAIT: begin
            a_in       = vrd_parent;
            am_rd_en   = 1'b1;
            am_rd_addr = vrd_parent[AW-1:1];
            state_in   = S_AUG_UPD;
         end
         S_AUG_UPD: begin
            am_wr_en = 1'b1;
            if (!a_ff[0]) begin
               am_wr_data.res_fwd = am_rd_data.res_fwd - incr_ff[15:0];
               am_wr_data.res_rev = am_rd_data.res_rev + incr_ff[15:0];
            end else begin
               am_wr_data.res_rev = am_rd_data.res_rev - incr_ff[15:0];
               am_wr_data.res_fwd = am_rd_data.res_fwd + incr_ff[15:0];
            end
            v_in     = NW'(cur_arc.tail);
            state_in = S_AUG_VSEL;
         end
         S_ACC_MUL: begin
            prod_in  = signed'({1'b0, incr_ff}) * dist_sink_ff;
            flow_in  = flow_ff + 23'(incr_ff);
            state_in = S_ACC_ADD;
         end
         S_ACC_ADD: begin
            cost_in  = cost_ff + 48'(prod_ff);
            state_in = S_REACH_INIT;
         end
         // Result output: per edge, one row read, then one transfer.
         S_OUT_RD: begin
            am_rd_en   = 1'b1;
            am_rd_addr = i_ff;
            state_in   = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.edge_number = 6'(i_ff);
               rsp_in.status      = status_ff;
               rsp_in.last_result = out_last;
               if (status_ff == ST_OK) begin
                  rsp_in.edge_flow  = am_rd_data.res_rev;
                  rsp_in.total_flow = flow_ff[21:0];
                  rsp_in.total_cost = cost_ff;
               end else begin
                  rsp_in.edge_flow  = '0;
                  rsp_in.total_flow = '0;
                  rsp_in.total_cost = '0;
               end
               if (out_last) begin
                  edges_in = '0;
                  maxv_in  = '0;
                  flow_in  = '0;
                  cost_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
         src_ff    <= 6'd0;
         snk_ff    <= 6'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vcount_ff <= csr_wdata;
            CSR_SOURCE_VERTEX: src_ff    <= csr_wdata[5:0];
            CSR_SINK_VERTEX:   snk_ff    <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         edges_ff     <= '0;
         maxv_ff      <= '0;
         flow_ff      <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         dvalid_ff    <= '0;
         changed_ff   <= 1'b0;
         updated_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edges_ff     <= edges_in;
         maxv_ff      <= maxv_in;
         flow_ff      <= flow_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         dvalid_ff    <= dvalid_in;
         changed_ff   <= changed_in;
         updated_ff   <= updated_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      a_ff         <= a_in;
      v_ff         <= v_in;
      pass_ff      <= pass_in;
      steps_ff     <= steps_in;
      dist_v_ff    <= dist_v_in;
      k_ff         <= k_in;
      h_ff         <= h_in;
      incr_ff      <= incr_in;
      dist_sink_ff <= dist_sink_in;
      prod_ff      <= prod_in;
      status_ff    <= status_in;
      i_ff         <= i_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   // A solve starts only after a transfer that carried the final edge.
   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> $past(req_valid && !req_stall && req_data.last_edge))
      else $error("solve started without a final edge");

   // The augmenting amount is never zero.
   a_incr_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AUG_UPD) |-> (incr_ff != '0))
      else $error("augment with zero bottleneck");

   // Error results carry no flow.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK))
         |-> ((rsp_data.total_flow == '0) && (rsp_data.edge_flow == '0)))
      else $error("error result with nonzero flow");

   // The load count stays within the arc memory.
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= EW'(MAX_EDGES))
      else $error("edge count overflow");
`endif

endmodule
